### rtl/core/gdc_pkg.sv
package gdc_pkg;

    // Reciprocal of 25 in 0.16 fixed point, exact for dividends below 4096
    localparam int unsigned DIV25_K     = 2622;
    localparam int unsigned DIV25_SHIFT = 16;
    localparam int unsigned DIV25       = 25;
    localparam int unsigned DAYS_YEAR   = 365;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_MAR = 4'd3;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] LEN_SHORT = 5'd30;
    localparam logic [4:0] LEN_LONG  = 5'd31;
    localparam logic [4:0] LEN_FEB   = 5'd28;
    localparam logic [4:0] LEN_FEB_L = 5'd29;

    typedef struct packed {
        logic [4:0]  d;
        logic [3:0]  m;
        logic [13:0] y;
        logic [13:0] py;
    } t_s1;

    typedef struct packed {
        logic [4:0]  d;
        logic [3:0]  m;
        logic [13:0] y;
        logic [13:0] py;
        logic [7:0]  qy;
        logic [7:0]  q100;
        logic [7:0]  q400;
        logic [22:0] p365;
    } t_s2;

    typedef struct packed {
        logic [4:0]  d;
        logic [3:0]  m;
        logic [13:0] y;
        logic        leap;
        logic [4:0]  len;
        logic [8:0]  doy;
        logic [22:0] base;
    } t_s3;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
            MONTH_FEB: len = leap ? LEN_FEB_L : LEN_FEB;
            default:   len = LEN_LONG;
        endcase
        return len;
    endfunction

    // Days in the months before month m of a common year
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] n;
        unique case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            default: n = 9'd334;
        endcase
        return n;
    endfunction

endpackage

### rtl/core/gdc_in_if.sv
interface gdc_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;

    modport source (output valid, output day, output month, output year, input ready);
    modport sink   (input valid, input day, input month, input year, output ready);
endinterface

### rtl/core/gdc_out_if.sv
interface gdc_out_if;
    logic        valid;
    logic        ready;
    logic        leap_year;
    logic [4:0]  month_length;
    logic [8:0]  day_of_year;
    logic [21:0] day_number;
    logic [4:0]  next_day;
    logic [3:0]  next_month;
    logic [13:0] next_year;
    logic [4:0]  prev_day;
    logic [3:0]  prev_month;
    logic [13:0] prev_year;

    modport source (
        output valid, output leap_year, output month_length, output day_of_year,
        output day_number, output next_day, output next_month, output next_year,
        output prev_day, output prev_month, output prev_year, input ready
    );
    modport sink (
        input valid, input leap_year, input month_length, input day_of_year,
        input day_number, input next_day, input next_month, input next_year,
        input prev_day, input prev_month, input prev_year, output ready
    );
endinterface

### rtl/core/gdc_sat_stage.sv
module gdc_sat_stage #(
    parameter int unsigned YEAR_MAX = 9999
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [4:0]    i_day,
    input  logic [3:0]    i_month,
    input  logic [13:0]   i_year,
    output logic          o_valid,
    input  logic          i_ready,
    output gdc_pkg::t_s1  o_data
);
    localparam logic [16:0] LP_YMAX = 17'(YEAR_MAX);

    logic         r_valid;
    gdc_pkg::t_s1 r_data;
    gdc_pkg::t_s1 n_data;
    logic         w_en;

    assign o_ready = !r_valid || i_ready;
    assign w_en    = i_valid && o_ready;

    always_comb begin
        n_data   = '0;
        n_data.d = i_day;
        // Pull month and year into range
        if (i_month < gdc_pkg::MONTH_JAN) begin
            n_data.m = gdc_pkg::MONTH_JAN;
        end else if (i_month > gdc_pkg::MONTH_DEC) begin
            n_data.m = gdc_pkg::MONTH_DEC;
        end else begin
            n_data.m = i_month;
        end
        if (i_year == 14'd0) begin
            n_data.y = 14'd1;
        end else if ({3'b000, i_year} > LP_YMAX) begin
            n_data.y = LP_YMAX[13:0];
        end else begin
            n_data.y = i_year;
        end
        n_data.py = n_data.y - 14'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

### rtl/core/gdc_mul_stage.sv
module gdc_mul_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  gdc_pkg::t_s1  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output gdc_pkg::t_s2  o_data
);
    localparam logic [23:0] LP_K    = 24'(gdc_pkg::DIV25_K);
    localparam int unsigned LP_SH   = gdc_pkg::DIV25_SHIFT;
    localparam logic [22:0] LP_365  = 23'(gdc_pkg::DAYS_YEAR);

    logic         r_valid;
    gdc_pkg::t_s2 r_data;
    gdc_pkg::t_s2 n_data;
    logic         w_en;
    logic [23:0]  w_py;
    logic [23:0]  w_p100;
    logic [23:0]  w_p400;

    assign o_ready = !r_valid || i_ready;
    assign w_en    = i_valid && o_ready;

    // Divide by 25 through the reciprocal; dividends stay below 4096
    always_comb begin
        w_py   = 24'(i_data.y[13:2]) * LP_K;
        w_p100 = 24'(i_data.py[13:2]) * LP_K;
        w_p400 = 24'(i_data.py[13:4]) * LP_K;
        n_data      = '0;
        n_data.d    = i_data.d;
        n_data.m    = i_data.m;
        n_data.y    = i_data.y;
        n_data.py   = i_data.py;
        n_data.qy   = w_py[LP_SH +: 8];
        n_data.q100 = w_p100[LP_SH +: 8];
        n_data.q400 = w_p400[LP_SH +: 8];
        n_data.p365 = 23'(i_data.py) * LP_365;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

### rtl/core/gdc_cal_stage.sv
module gdc_cal_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  gdc_pkg::t_s2  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output gdc_pkg::t_s3  o_data
);
    localparam logic [11:0] LP_25 = 12'(gdc_pkg::DIV25);

    logic         r_valid;
    gdc_pkg::t_s3 r_data;
    gdc_pkg::t_s3 n_data;
    logic         w_en;
    logic [11:0]  w_rem;
    logic         w_leap;
    logic [4:0]   w_len;
    logic [4:0]   w_d;
    logic         w_bump;

    assign o_ready = !r_valid || i_ready;
    assign w_en    = i_valid && o_ready;

    always_comb begin
        // (year / 4) mod 25; zero means year is a multiple of 100 when it is of 4
        w_rem  = i_data.y[13:2] - 12'(i_data.qy) * LP_25;
        w_leap = (i_data.y[1:0] == 2'b00) && ((w_rem != 12'd0) || (i_data.y[3:2] == 2'b00));
        w_len  = gdc_pkg::month_len(i_data.m, w_leap);
        if (i_data.d == 5'd0) begin
            w_d = 5'd1;
        end else if (i_data.d > w_len) begin
            w_d = w_len;
        end else begin
            w_d = i_data.d;
        end
        w_bump = w_leap && (i_data.m > gdc_pkg::MONTH_FEB);

        n_data      = '0;
        n_data.d    = w_d;
        n_data.m    = i_data.m;
        n_data.y    = i_data.y;
        n_data.leap = w_leap;
        n_data.len  = w_len;
        n_data.doy  = gdc_pkg::days_before(i_data.m) + 9'(w_d) + 9'(w_bump);
        n_data.base = i_data.p365 + 23'(i_data.py[13:2]) - 23'(i_data.q100)
                    + 23'(i_data.q400);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

### rtl/core/gdc_out_stage.sv
module gdc_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  gdc_pkg::t_s3  i_data,
    gdc_out_if.source     o_out
);
    logic        r_valid;
    logic        r_leap;
    logic [4:0]  r_len;
    logic [8:0]  r_doy;
    logic [21:0] r_dn;
    logic [4:0]  r_nd;
    logic [3:0]  r_nm;
    logic [13:0] r_ny;
    logic [4:0]  r_pd;
    logic [3:0]  r_pm;
    logic [13:0] r_py;
    logic [22:0] w_dn;
    logic [4:0]  n_nd;
    logic [3:0]  n_nm;
    logic [13:0] n_ny;
    logic [4:0]  n_pd;
    logic [3:0]  n_pm;
    logic [13:0] n_py;
    logic        w_en;

    assign o_ready = !r_valid || o_out.ready;
    assign w_en    = i_valid && o_ready;

    always_comb begin
        w_dn = i_data.base + 23'(i_data.doy);

        n_nd = i_data.d + 5'd1;
        n_nm = i_data.m;
        n_ny = i_data.y;
        if (i_data.d == i_data.len) begin
            n_nd = 5'd1;
            if (i_data.m == gdc_pkg::MONTH_DEC) begin
                n_nm = gdc_pkg::MONTH_JAN;
                n_ny = i_data.y + 14'd1;
            end else begin
                n_nm = i_data.m + 4'd1;
            end
        end

        // Going back into February keeps the same year, so its leap flag holds
        n_pd = i_data.d - 5'd1;
        n_pm = i_data.m;
        n_py = i_data.y;
        if (i_data.d == 5'd1) begin
            if (i_data.m == gdc_pkg::MONTH_JAN) begin
                n_pm = gdc_pkg::MONTH_DEC;
                n_py = i_data.y - 14'd1;
            end else begin
                n_pm = i_data.m - 4'd1;
            end
            n_pd = gdc_pkg::month_len(n_pm, i_data.leap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_leap <= i_data.leap;
            r_len  <= i_data.len;
            r_doy  <= i_data.doy;
            r_dn   <= w_dn[21:0];
            r_nd   <= n_nd;
            r_nm   <= n_nm;
            r_ny   <= n_ny;
            r_pd   <= n_pd;
            r_pm   <= n_pm;
            r_py   <= n_py;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.leap_year    = r_leap;
    assign o_out.month_length = r_len;
    assign o_out.day_of_year  = r_doy;
    assign o_out.day_number   = r_dn;
    assign o_out.next_day     = r_nd;
    assign o_out.next_month   = r_nm;
    assign o_out.next_year    = r_ny;
    assign o_out.prev_day     = r_pd;
    assign o_out.prev_month   = r_pm;
    assign o_out.prev_year    = r_py;
endmodule

### rtl/core/gregorian_date_converter.sv
// Gregorian date converter.
// Input channel i_in carries one date per beat (day, month, year). Output
// channel o_out carries one result beat per date: leap flag, month length,
// day of year, day number counted from 1/1/1, and the following and the
// preceding dates. Fields out of range are pulled to the nearest legal value
// first (year to 1..YEAR_MAX, month to 1..12, day to 1..month length).
// Both channels use valid/ready; a beat moves when both are high.
// A new date may enter every cycle while the receiver keeps ready high, so
// throughput is then one beat per cycle. The four register stages are:
// range clamp, reciprocal multiplies (divide by 25 and 365 times year - 1),
// leap flag with day-of-year, and the final sums with the next and previous
// dates.
// Each stage holds its own valid bit and takes a new beat when it is empty or
// its successor moves, so bubbles are squeezed out during a stall.
// When the receiver holds ready low, the result beat holds and the pipeline
// fills; i_in.ready drops only once every stage is occupied.
// Synchronous active-low reset empties all stages; no result is lost or
// repeated across a stall.
module gregorian_date_converter #(
    parameter int unsigned YEAR_MAX = 9999
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gdc_in_if.sink    i_in,
    gdc_out_if.source o_out
);
    logic         w_v1;
    logic         w_r1;
    gdc_pkg::t_s1 w_d1;
    logic         w_v2;
    logic         w_r2;
    gdc_pkg::t_s2 w_d2;
    logic         w_v3;
    logic         w_r3;
    gdc_pkg::t_s3 w_d3;

    // Stage 1: clamp year and month, form year - 1
    gdc_sat_stage #(
        .YEAR_MAX (YEAR_MAX)
    ) u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_day   (i_in.day),
        .i_month (i_in.month),
        .i_year  (i_in.year),
        .o_valid (w_v1),
        .i_ready (w_r1),
        .o_data  (w_d1)
    );

    // Stage 2: quotients by 100 and 400, days in whole years
    gdc_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v1),
        .o_ready (w_r1),
        .i_data  (w_d1),
        .o_valid (w_v2),
        .i_ready (w_r2),
        .o_data  (w_d2)
    );

    // Stage 3: leap flag, month length, day clamp, day of year, whole-year day base
    gdc_cal_stage u_cal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v2),
        .o_ready (w_r2),
        .i_data  (w_d2),
        .o_valid (w_v3),
        .i_ready (w_r3),
        .o_data  (w_d3)
    );

    // Stage 4: day number, neighbor dates, output register
    gdc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v3),
        .o_ready (w_r3),
        .i_data  (w_d3),
        .o_out   (o_out)
    );

    // A 28-day month only occurs in a common year
    a_feb_common: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.month_length == gdc_pkg::LEN_FEB)) |-> !o_out.leap_year)
        else $error("28-day month flagged as leap year");

    // Day of year never passes the year length
    a_doy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.day_of_year <= (9'd365 + 9'(o_out.leap_year)))
                         && (o_out.day_of_year != 9'd0)))
        else $error("day of year out of range");

    // On a month's last day the neighbor dates lie in different months
    a_month_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.next_day == 5'd1)) |-> (o_out.next_month != o_out.prev_month))
        else $error("month rollover inconsistent");

    // Stage 3 holds a clamped day within its month
    a_day_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v3 |-> ((w_d3.d != 5'd0) && (w_d3.d <= w_d3.len)))
        else $error("day not clamped to month length");
endmodule

### dv/gregorian_date_converter_tb.sv
`timescale 1ns / 100ps

module gregorian_date_converter_tb;

    // Block configuration and run pacing
    localparam int unsigned YEAR_LIMIT   = 9999;
    localparam int          RANDOM_DATES = 1400;
    localparam int          HOLD_CYCLES  = 64;   // long output hold-off, well past pipeline depth
    localparam int          DRAIN_CYCLES = 12;   // drain time, longer than the pipeline depth
    localparam int          MAX_REPORTS  = 10;
    localparam int          TIMEOUT_NS   = 2_000_000;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } t_date_in;

    typedef struct packed {
        logic        leap_year;
        logic [4:0]  month_length;
        logic [8:0]  day_of_year;
        logic [21:0] day_number;
        logic [4:0]  next_day;
        logic [3:0]  next_month;
        logic [13:0] next_year;
        logic [4:0]  prev_day;
        logic [3:0]  prev_month;
        logic [13:0] prev_year;
    } t_date_result;

    // One outstanding conversion: the date that went in and what must come out
    typedef struct packed {
        t_date_in     src;
        t_date_result res;
    } t_date_expect;

    logic i_clk;
    logic i_rst_n;

    gdc_in_if  in_if ();
    gdc_out_if out_if ();

    gregorian_date_converter #(
        .YEAR_MAX (YEAR_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_date_in     pending_dates[$];    // dates not yet accepted by the block
    t_date_expect expected_dates[$];   // accepted dates whose result beat is still due
    t_date_result observed;

    int n_total;
    int n_directed;
    int n_sent;
    int n_checked;
    int n_errors;
    int n_leap_seen;
    int n_in_stalls;
    int hold_cnt;
    bit hold_done;
    int hold_at;

    // Gather the result fields into one struct for comparison
    assign observed = {out_if.leap_year, out_if.month_length, out_if.day_of_year,
                       out_if.day_number, out_if.next_day, out_if.next_month,
                       out_if.next_year, out_if.prev_day, out_if.prev_month,
                       out_if.prev_year};

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    function automatic bit is_leap_year(int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        int unsigned len;
        case (m)
            gdc_pkg::MONTH_APR, gdc_pkg::MONTH_JUN, gdc_pkg::MONTH_SEP,
            gdc_pkg::MONTH_NOV: len = 32'(gdc_pkg::LEN_SHORT);
            gdc_pkg::MONTH_FEB: len = is_leap_year(y) ? 32'(gdc_pkg::LEN_FEB_L)
                                                      : 32'(gdc_pkg::LEN_FEB);
            default:            len = 32'(gdc_pkg::LEN_LONG);
        endcase
        return len;
    endfunction

    function automatic t_date_result convert_date(t_date_in din);
        int unsigned  d, m, y, len, doy, py, dn;
        int unsigned  nd, nm, ny, pd, pm, pyr;
        bit           leap;
        t_date_result r;

        d = 32'(din.day);
        m = 32'(din.month);
        y = 32'(din.year);

        // Pull out-of-range fields to the nearest legal value: month and
        // year first, then the day against the length of that month
        if (m < gdc_pkg::MONTH_JAN) m = 32'(gdc_pkg::MONTH_JAN);
        if (m > gdc_pkg::MONTH_DEC) m = 32'(gdc_pkg::MONTH_DEC);
        if (y < 1) y = 1;
        if (y > YEAR_LIMIT) y = YEAR_LIMIT;

        leap = is_leap_year(y);
        len  = days_in_month(m, y);
        if (d < 1) d = 1;
        if (d > len) d = len;

        // Days in the months ahead of m in a common year
        case (m)
            1:       doy = 0;
            2:       doy = 31;
            3:       doy = 59;
            4:       doy = 90;
            5:       doy = 120;
            6:       doy = 151;
            7:       doy = 181;
            8:       doy = 212;
            9:       doy = 243;
            10:      doy = 273;
            11:      doy = 304;
            default: doy = 334;
        endcase
        doy = doy + d + ((leap && m > gdc_pkg::MONTH_FEB) ? 1 : 0);

        py = y - 1;
        dn = gdc_pkg::DAYS_YEAR * py + py / 4 - py / 100 + py / 400 + doy;

        // Following date, rolling month and year forward
        nd = d + 1;
        nm = m;
        ny = y;
        if (nd > len) begin
            nd = 1;
            nm = m + 1;
            if (nm > gdc_pkg::MONTH_DEC) begin
                nm = 32'(gdc_pkg::MONTH_JAN);
                ny = y + 1;
            end
        end

        // Preceding date, rolling back; year 1 goes back to year 0
        pd  = d - 1;
        pm  = m;
        pyr = y;
        if (pd == 0) begin
            pm = m - 1;
            if (pm == 0) begin
                pm  = 32'(gdc_pkg::MONTH_DEC);
                pyr = y - 1;
            end
            pd = days_in_month(pm, pyr);
        end

        r.leap_year    = leap;
        r.month_length = 5'(len);
        r.day_of_year  = 9'(doy);
        r.day_number   = 22'(dn);
        r.next_day     = 5'(nd);
        r.next_month   = 4'(nm);
        r.next_year    = 14'(ny);
        r.prev_day     = 5'(pd);
        r.prev_month   = 4'(pm);
        r.prev_year    = 14'(pyr);
        return r;
    endfunction

    // Name every field of a result beat that disagrees with the prediction
    function automatic string field_diffs(t_date_result want, t_date_result got);
        string s;
        s = "";
        if (got.leap_year    !== want.leap_year)    s = {s, " leap_year"};
        if (got.month_length !== want.month_length) s = {s, " month_length"};
        if (got.day_of_year  !== want.day_of_year)  s = {s, " day_of_year"};
        if (got.day_number   !== want.day_number)   s = {s, " day_number"};
        if (got.next_day     !== want.next_day)     s = {s, " next_day"};
        if (got.next_month   !== want.next_month)   s = {s, " next_month"};
        if (got.next_year    !== want.next_year)    s = {s, " next_year"};
        if (got.prev_day     !== want.prev_day)     s = {s, " prev_day"};
        if (got.prev_month   !== want.prev_month)   s = {s, " prev_month"};
        if (got.prev_year    !== want.prev_year)    s = {s, " prev_year"};
        return s;
    endfunction

    function automatic string fmt_result(t_date_result r);
        return $sformatf("leap=%0d len=%0d doy=%0d dn=%0d next=%0d/%0d/%0d prev=%0d/%0d/%0d",
                         r.leap_year, r.month_length, r.day_of_year, r.day_number,
                         r.next_day, r.next_month, r.next_year,
                         r.prev_day, r.prev_month, r.prev_year);
    endfunction

    // Queue one date for the driver
    task automatic add_date(int unsigned d, int unsigned m, int unsigned y);
        t_date_in item;
        item.day   = 5'(d);
        item.month = 4'(m);
        item.year  = 14'(y);
        pending_dates.push_back(item);
    endtask

    // Pacing phase from progress: sender-light/receiver-heavy idling first,
    // then the reverse, then no idling at all
    function automatic int pacing_phase();
        if (n_sent < n_total / 3)     return 0;
        if (n_sent < 2 * n_total / 3) return 1;
        return 2;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Driver: offer pending dates, hold each one until its beat moves
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && !in_if.ready) n_in_stalls <= n_in_stalls + 1;

            // Beat moved: retire it and record what the block owes us
            if (in_if.valid && in_if.ready) begin
                t_date_expect e;
                e.src = pending_dates.pop_front();
                e.res = convert_date(e.src);
                expected_dates.push_back(e);
                n_sent <= n_sent + 1;
            end

            // Hold the current beat while it is stalled; otherwise present
            // the next date or idle
            if (!in_if.valid || in_if.ready) begin
                if (pending_dates.size() != 0 &&
                    $urandom_range(99, 0) >= (pacing_phase() == 0 ? 20 :
                                              pacing_phase() == 1 ? 65 : 0)) begin
                    in_if.valid <= 1'b1;
                    in_if.day   <= pending_dates[0].day;
                    in_if.month <= pending_dates[0].month;
                    in_if.year  <= pending_dates[0].year;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted on its own. Start it in the no-idle
    // phase so the sender keeps pushing and the pipeline backs up.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_sent >= hold_at) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result beat against the oldest expectation and
    // pace ready for the next cycle
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_dates.size() == 0) begin
                    n_errors <= n_errors + 1;
                    if (n_errors < MAX_REPORTS)
                        $display("ERROR: result beat with nothing outstanding: %s",
                                 fmt_result(observed));
                end else begin
                    t_date_expect e;
                    string        diffs;
                    e     = expected_dates.pop_front();
                    diffs = field_diffs(e.res, observed);
                    n_checked <= n_checked + 1;
                    if (observed.leap_year === 1'b1) n_leap_seen <= n_leap_seen + 1;
                    if (diffs != "") begin
                        n_errors <= n_errors + 1;
                        if (n_errors < MAX_REPORTS) begin
                            $display("ERROR: date %0d/%0d/%0d, wrong:%s",
                                     e.src.day, e.src.month, e.src.year, diffs);
                            $display("    expected %s", fmt_result(e.res));
                            $display("    actual   %s", fmt_result(observed));
                        end
                    end
                end
            end

            // Drop ready for the whole hold-off, otherwise idle per phase
            if (hold_cnt > 0)
                out_if.ready <= 1'b0;
            else
                out_if.ready <= $urandom_range(99, 0) >= (pacing_phase() == 0 ? 65 :
                                                          pacing_phase() == 1 ? 20 : 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------

    initial begin
        int unsigned d, m, y, len;

        // Known values on every block input from time zero
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.day    = '0;
        in_if.month  = '0;
        in_if.year   = '0;
        out_if.ready = 1'b0;
        n_sent       = 0;
        n_checked    = 0;
        n_errors     = 0;
        n_leap_seen  = 0;
        n_in_stalls  = 0;

        // Directed dates: calendar corners and every saturation path
        add_date(1, 1, 1);          // first day of the calendar, previous year is 0
        add_date(31, 12, 9999);     // last day of the top year, next year rolls past it
        add_date(1, 1, 9999);
        add_date(29, 2, 2000);      // divisible by 400: leap
        add_date(28, 2, 1900);      // century, not by 400: common
        add_date(29, 2, 1900);      // day clamps to 28
        add_date(29, 2, 2024);      // ordinary leap year
        add_date(1, 3, 2024);       // previous date is February 29
        add_date(1, 3, 2023);       // previous date is February 28
        add_date(31, 12, 2023);     // year rolls forward
        add_date(1, 1, 2024);       // year rolls back
        add_date(30, 4, 2024);      // end of a short month
        add_date(31, 4, 2024);      // day clamps to 30
        add_date(31, 1, 2024);      // end of a long month
        add_date(0, 5, 2024);       // day zero lifts to 1
        add_date(15, 0, 2024);      // month zero lifts to January
        add_date(15, 13, 2024);     // month above 12 pulls to December
        add_date(10, 6, 0);         // year zero lifts to 1
        add_date(10, 6, 10000);     // year above the top pulls down
        add_date(31, 15, 16383);    // every input bit high
        add_date(0, 0, 0);          // every input bit low
        add_date(29, 2, 400);
        add_date(28, 2, 2100);
        add_date(31, 12, 1);
        n_directed = pending_dates.size();

        // Random dates: mostly well-formed with edge-heavy content, some noise
        for (int i = 0; i < RANDOM_DATES; i++) begin
            if ($urandom_range(99, 0) < 15) begin
                add_date($urandom_range(31, 0), $urandom_range(15, 0), $urandom_range(16383, 0));
            end else begin
                m = $urandom_range(12, 1);
                case ($urandom_range(9, 0))
                    0:       y = $urandom_range(5, 1);
                    1:       y = $urandom_range(9999, 9995);
                    2:       y = $urandom_range(99, 1) * 100;
                    3:       y = $urandom_range(24, 1) * 400;
                    default: y = $urandom_range(9999, 1);
                endcase
                len = days_in_month(m, y);
                case ($urandom_range(4, 0))
                    0:       d = 1;
                    1:       d = len;
                    2:       d = len - 1;
                    default: d = $urandom_range(len, 1);
                endcase
                add_date(d, m, y);
            end
        end
        n_total = pending_dates.size();
        hold_at = 5 * n_total / 6;

        // Hold reset, then release it on a rising edge
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Advance until every date is in and every result is out
        while (pending_dates.size() != 0 || expected_dates.size() != 0)
            @(posedge i_clk);

        // Let the pipeline drain so a stray extra beat would still show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_dates.size() != 0) begin
            n_errors = n_errors + expected_dates.size();
            $display("ERROR: %0d results never arrived", expected_dates.size());
        end

        $display("Checked %0d of %0d dates (%0d directed, %0d leap-year results), with",
                 n_checked, n_total, n_directed, n_leap_seen);
        $display("mixed, reversed and no idling; input held off for %0d cycles; %0d errors",
                 n_in_stalls, n_errors);

        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("ERROR: run timed out with %0d dates pending, %0d results due",
                 pending_dates.size(), expected_dates.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/core/gdc_pkg.sv
rtl/core/gdc_in_if.sv
rtl/core/gdc_out_if.sv
rtl/core/gdc_sat_stage.sv
rtl/core/gdc_mul_stage.sv
rtl/core/gdc_cal_stage.sv
rtl/core/gdc_out_stage.sv
rtl/core/gregorian_date_converter.sv
dv/gregorian_date_converter_tb.sv
